/* rtl/core/thcp_pkg.sv */
// Shared types and constants for the TDC hit calibrate/pair block.
// Used by thcp_front, thcp_queue, thcp_back and tdc_hit_calibrate_pair.
// No dependencies.
package thcp_pkg;

    localparam int DATA_W      = 32;
    localparam int RESULT_W    = 51;
    localparam int COARSE_W    = 15;
    localparam int FINE_W      = 9;
    localparam int GAIN_W      = 13;
    localparam int OFFSET_W    = 22;
    localparam int PRODUCT_W   = FINE_W + GAIN_W;
    localparam int PHASE_W     = 24;
    localparam int SCALED_W    = PHASE_W + FINE_W + 1;
    localparam int PERIOD_LOG2 = 20;
    localparam int TDC_COUNT   = 4;
    localparam int LEAD_COUNT  = 2;
    localparam int DIFF_W      = 7;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = OFFSET_W;

    // default depth of the front-to-back queue
    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0]          HDR_CODE  = 4'h7;
    localparam logic [3:0]          TRL_CODE  = 4'hF;
    localparam logic [DATA_W-1:0]   KILL_WORD = 32'h666C_AFFE;
    localparam logic [DATA_W-1:0]   ROLL_WORD = 32'h5C5C_5C5C;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 13'd2052;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;

    localparam logic signed [PHASE_W-1:0]  PHASE_PERIOD = 24'sd1048576;
    localparam logic signed [SCALED_W-1:0] PHASE_HALF   = 34'sd524288;
    localparam logic [FINE_W-1:0]          FINE_MAX     = 9'd511;
    localparam logic [COARSE_W-1:0]        COARSE_MAX   = 15'h7FFF;

    localparam logic KIND_RAW = 1'b0;
    localparam logic KIND_HIT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_TDC0   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_TDC0 = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_END         = 4'd8;

    typedef struct packed {
        logic [DATA_W-1:0] data_word;
        logic              buffer_first;
    } in_item_t;

    typedef struct packed {
        logic                result_kind;
        logic [RESULT_W-1:0] result_word;
    } out_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] word;
        logic              buffer_first;
        logic              is_hit;
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef logic [TDC_COUNT-1:0][GAIN_W-1:0]   gain_bank_t;
    typedef logic [TDC_COUNT-1:0][OFFSET_W-1:0] offset_bank_t;

endpackage

/* rtl/core/thcp_front.sv */
// Front end: accepts readout words, tracks spill framing, tags hits.
// Pushes classified words into thcp_queue. Depends on thcp_pkg.
module thcp_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  thcp_pkg::in_item_t      s_data,
    input  thcp_pkg::queue_status_t q_status,
    output logic                    push,
    output thcp_pkg::queue_entry_t  push_entry
);
    import thcp_pkg::*;

    logic       in_spill_reg, in_spill_next;
    logic       pass_next_reg, pass_next_next;
    logic       is_hit;
    logic [3:0] nibble;

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;
    assign nibble  = s_data.data_word[DATA_W-1 -: 4];

    always_comb begin
        in_spill_next  = in_spill_reg;
        pass_next_next = pass_next_reg;
        is_hit         = 1'b0;
        if (pass_next_reg) begin
            pass_next_next = 1'b0;
        end else if (!in_spill_reg) begin
            if (nibble == HDR_CODE) begin
                in_spill_next  = 1'b1;
                pass_next_next = 1'b1;
            end
        end else if (s_data.data_word == KILL_WORD) begin
            in_spill_next = 1'b0;
        end else if (nibble == TRL_CODE) begin
            in_spill_next  = 1'b0;
            pass_next_next = 1'b1;
        end else if (s_data.data_word != ROLL_WORD) begin
            is_hit = 1'b1;
        end
    end

    assign push_entry.word         = s_data.data_word;
    assign push_entry.buffer_first = s_data.buffer_first;
    assign push_entry.is_hit       = is_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_spill_reg  <= 1'b0;
            pass_next_reg <= 1'b0;
        end else if (push) begin
            in_spill_reg  <= in_spill_next;
            pass_next_reg <= pass_next_next;
        end
    end

endmodule

/* rtl/core/thcp_queue.sv */
// Short FIFO of classified words between front and back end.
// Register based, head visible combinationally. Depends on thcp_pkg.
module thcp_queue #(
    parameter int DEPTH = thcp_pkg::QUEUE_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  thcp_pkg::queue_entry_t  push_entry,
    input  logic                    pop,
    output thcp_pkg::queue_entry_t  head_entry,
    output thcp_pkg::queue_status_t status
);
    import thcp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_entry_t     entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_entry   = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        status.full && !pop |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        status.empty |-> !pop)
        else $error("pop from empty queue");

endmodule

/* rtl/core/thcp_back.sv */
// Back end: calibrates hits, pairs trailing with leading edges, drives results.
// Stage A multiplies code by gain and adds offset, stage B adjusts and packs.
// Depends on thcp_pkg.
module thcp_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  thcp_pkg::queue_status_t q_status,
    input  thcp_pkg::queue_entry_t  head_entry,
    output logic                    pop,
    input  thcp_pkg::gain_bank_t    gain_bank,
    input  thcp_pkg::offset_bank_t  offset_bank,
    output logic                    m_valid,
    input  logic                    m_ready,
    output thcp_pkg::out_item_t     m_data
);
    import thcp_pkg::*;

    // stage A
    logic                       a_valid_reg;
    logic [DATA_W-1:0]          a_word_reg;
    logic                       a_start_reg;
    logic                       a_hit_reg;
    logic signed [PHASE_W-1:0]  a_phase_reg;
    logic                       a_go;
    logic                       out_free;

    logic [1:0]                 q_tdc;
    logic [PRODUCT_W-1:0]       product;
    logic [OFFSET_W-1:0]        q_offset;
    logic signed [PHASE_W-1:0]  phase_load;

    // stage B
    logic [1:0]                 tdc;
    logic                       lead_idx;
    logic [COARSE_W-1:0]        coarse_raw, coarse_adj;
    logic signed [PHASE_W-1:0]  phase_adj;
    logic signed [SCALED_W-1:0] phase_ext, scaled;
    logic [FINE_W-1:0]          fine;
    logic                       lv_eff;
    logic [COARSE_W-1:0]        lc_eff;
    logic [FINE_W-1:0]          lf_eff;
    logic [COARSE_W:0]          diff_full;
    logic                       pair_ok;
    logic                       emit;
    logic [RESULT_W-1:0]        hit_word;

    logic [LEAD_COUNT-1:0]                lead_valid_reg, lead_valid_next;
    logic [LEAD_COUNT-1:0][COARSE_W-1:0]  lead_coarse_reg, lead_coarse_next;
    logic [LEAD_COUNT-1:0][FINE_W-1:0]    lead_fine_reg, lead_fine_next;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    assign out_free = !m_valid_reg || m_ready;
    assign a_go     = a_valid_reg && out_free;
    assign pop      = !q_status.empty && (!a_valid_reg || a_go);

    // stage A: phase = offset + code * gain
    assign q_tdc      = head_entry.word[25:24];
    assign q_offset   = offset_bank[q_tdc];
    assign product    = {{GAIN_W{1'b0}}, head_entry.word[FINE_W-1:0]}
                      * {{FINE_W{1'b0}}, gain_bank[q_tdc]};
    assign phase_load = $signed({2'b00, product})
                      + $signed({{(PHASE_W-OFFSET_W){q_offset[OFFSET_W-1]}}, q_offset});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (pop) begin
            a_valid_reg <= 1'b1;
        end else if (a_go) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            a_word_reg  <= head_entry.word;
            a_start_reg <= head_entry.buffer_first;
            a_hit_reg   <= head_entry.is_hit;
            a_phase_reg <= phase_load;
        end
    end

    // stage B: one borrow or carry into coarse, then round to 511 steps
    assign tdc        = a_word_reg[25:24];
    assign lead_idx   = tdc[0];
    assign coarse_raw = a_word_reg[FINE_W +: COARSE_W];

    always_comb begin
        coarse_adj = coarse_raw;
        phase_adj  = a_phase_reg;
        if (a_phase_reg < 0) begin
            if (coarse_raw != '0) begin
                coarse_adj = coarse_raw - 1'b1;
                phase_adj  = a_phase_reg + PHASE_PERIOD;
            end else begin
                phase_adj = '0;
            end
        end else if (a_phase_reg > PHASE_PERIOD) begin
            if (coarse_raw != COARSE_MAX) begin
                coarse_adj = coarse_raw + 1'b1;
                phase_adj  = a_phase_reg - PHASE_PERIOD;
            end else begin
                phase_adj = PHASE_PERIOD;
            end
        end
    end

    // times 511 as (p << 9) - p
    assign phase_ext = {{(SCALED_W-PHASE_W){phase_adj[PHASE_W-1]}}, phase_adj};
    assign scaled    = (phase_ext <<< FINE_W) - phase_ext + PHASE_HALF;

    always_comb begin
        if (scaled[SCALED_W-1]) begin
            fine = '0;
        end else if (scaled[SCALED_W-1:PERIOD_LOG2]
                     > (SCALED_W-PERIOD_LOG2)'(FINE_MAX)) begin
            fine = FINE_MAX;
        end else begin
            fine = scaled[PERIOD_LOG2 +: FINE_W];
        end
    end

    // buffer start wipes the stored edges before this word is handled
    assign lv_eff = a_start_reg ? 1'b0 : lead_valid_reg[lead_idx];
    assign lc_eff = a_start_reg ? '0   : lead_coarse_reg[lead_idx];
    assign lf_eff = a_start_reg ? '0   : lead_fine_reg[lead_idx];

    // a negative difference counts as huge
    assign diff_full = {1'b0, coarse_adj} - {1'b0, lc_eff};
    assign pair_ok   = (diff_full[COARSE_W:DIFF_W] == '0);

    assign hit_word = (RESULT_W'(2'd2) << 48)
                    | (RESULT_W'(tdc) << 46)
                    | (RESULT_W'(diff_full[DIFF_W-1:0]) << 39)
                    | (RESULT_W'(fine) << 30)
                    | (RESULT_W'(a_word_reg[DATA_W-1:26]) << 24)
                    | (RESULT_W'(lead_idx) << 22)
                    | (RESULT_W'(lc_eff) << 9)
                    | RESULT_W'(lf_eff);

    assign emit = a_go && (!a_hit_reg || (tdc[1] && pair_ok && lv_eff));

    always_comb begin
        lead_valid_next  = lead_valid_reg;
        lead_coarse_next = lead_coarse_reg;
        lead_fine_next   = lead_fine_reg;
        if (a_go) begin
            if (a_start_reg) begin
                lead_valid_next  = '0;
                lead_coarse_next = '0;
                lead_fine_next   = '0;
            end
            if (a_hit_reg) begin
                if (!tdc[1]) begin
                    lead_valid_next[lead_idx]  = 1'b1;
                    lead_coarse_next[lead_idx] = coarse_adj;
                    lead_fine_next[lead_idx]   = fine;
                end else if (!pair_ok || lv_eff) begin
                    lead_valid_next[lead_idx] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            if (a_hit_reg) begin
                m_data_next.result_kind = KIND_HIT;
                m_data_next.result_word = hit_word;
            end else begin
                m_data_next.result_kind = KIND_RAW;
                m_data_next.result_word = RESULT_W'(a_word_reg);
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_valid_reg  <= '0;
            lead_coarse_reg <= '0;
            lead_fine_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            lead_valid_reg  <= lead_valid_next;
            lead_coarse_reg <= lead_coarse_next;
            lead_fine_reg   <= lead_fine_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_hit_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.result_kind == KIND_HIT)
        |-> m_data_reg.result_word[49] && !m_data_reg.result_word[50]
            && m_data_reg.result_word[47])
        else $error("hit word without marker bits");

    a_raw_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.result_kind == KIND_RAW)
        |-> (m_data_reg.result_word[RESULT_W-1:DATA_W] == '0))
        else $error("raw word with upper bits set");

    a_stage_a_held: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !out_free |=> a_valid_reg && $stable(a_word_reg))
        else $error("stage A item lost while output stalled");

endmodule

/* rtl/core/tdc_hit_calibrate_pair.sv */
// TDC hit calibrate/pair: top level with the configuration registers.
// Instantiates thcp_front, thcp_queue and thcp_back. Depends on thcp_pkg.
//
// Input channel s_*: one 32-bit readout word per request plus a buffer-start
// flag. Outside a spill words go out raw; a header opens the spill. Inside,
// kill, trailer and rollover words go out raw and hits are calibrated.
// Leading edges (TDC 0/1) are stored; a trailing edge (TDC 2/3) within 127
// coarse counts of its lead gives one packed 51-bit hit on m_*.
// Configuration channel cfg_*: index 0..3 gain of TDC 0..3, 4..7 offset of
// TDC 0..3; other indexes are ignored. cfg_ready is always high. Write only
// while the block is idle.
// Throughput: one word per cycle sustained while m_ready is high. On the way
// to m_valid: queue write at the s_* accepting edge, gain multiply and offset
// add into stage A, then coarse adjust, rounding and pairing into the output
// register. When m_ready is low a valid output register holds, the back end
// stops and the queue (QUEUE_DEPTH entries) fills before s_ready drops.
// Synchronous reset (aresetn low) clears spill state, stored edges, queue
// and output valid, and loads gains 2052 and offsets 0.
module tdc_hit_calibrate_pair #(
    parameter int QUEUE_DEPTH = thcp_pkg::QUEUE_DEPTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  thcp_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output thcp_pkg::out_item_t                   m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [thcp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [thcp_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import thcp_pkg::*;

    gain_bank_t    gain_reg;
    offset_bank_t  offset_reg;
    logic          cfg_write;

    logic          push, pop;
    queue_entry_t  push_entry, head_entry;
    queue_status_t q_status;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= {TDC_COUNT{GAIN_RESET}};
            offset_reg <= {TDC_COUNT{OFFSET_RESET}};
        end else if (cfg_write) begin
            if (cfg_index < CFG_OFFSET_TDC0) begin
                gain_reg[cfg_index[1:0]] <= cfg_data[GAIN_W-1:0];
            end else if (cfg_index < CFG_END) begin
                offset_reg[cfg_index[1:0]] <= cfg_data[OFFSET_W-1:0];
            end
        end
    end

    thcp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    thcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    thcp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_status    (q_status),
        .head_entry  (head_entry),
        .pop         (pop),
        .gain_bank   (gain_reg),
        .offset_bank (offset_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
